// ----- rtl/bfiq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfiq_pkg: shared constants, codes and types of the Bloom filter core
// Sizes of the filter and hash limits, the prime table, the hash unit
// operation codes and the control structs passed between the modules.
// ----------------------------------------------------------------------------
package bfiq_pkg;

  // Filter and hash limits.
  localparam int MAX_BITS     = 65536;
  localparam int MAX_HASHES   = 16;

  // Field and register widths.
  localparam int KEY_W        = 64;
  localparam int BIT_COUNT_W  = 17;
  localparam int HASH_COUNT_W = 5;
  localparam int CFG_DATA_W   = 17;
  localparam int CFG_INDEX_W  = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_BIT_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT = 2'd1;

  // Register reset values.
  localparam logic [BIT_COUNT_W-1:0]  BIT_COUNT_RST  = 17'd65536;
  localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = 5'd1;

  // Mersenne prime 2^31-1 used as the first modulus.
  localparam int                MERS_W     = 31;
  localparam logic [MERS_W-1:0] MERSENNE31 = 31'h7FFF_FFFF;

  // Bit index and final modulus widths.
  localparam int IDX_W = $clog2(MAX_BITS);
  localparam int DIV_W = IDX_W + 1;

  // Hash counter widths.
  localparam int HASH_IDX_W = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int HASH_CNT_W = $clog2(MAX_HASHES + 1);

  // Bit array organized as rows of ROW_W bits.
  localparam int ROW_W     = (MAX_BITS < 32) ? MAX_BITS : 32;
  localparam int ROW_SEL_W = $clog2(ROW_W);
  localparam int ROWS      = MAX_BITS / ROW_W;
  localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Remainder unit: dividend padded to DVD_W bits, MOD_STEP bits per cycle.
  localparam int DVD_W     = 32;
  localparam int MOD_STEP  = 4;
  localparam int MOD_CYC   = DVD_W / MOD_STEP;
  localparam int MOD_CNT_W = $clog2(MOD_CYC);

  // Hash unit operation codes.
  localparam int GOP_W = 3;
  localparam logic [GOP_W-1:0] GOP_NONE   = 3'd0;
  localparam logic [GOP_W-1:0] GOP_LOAD   = 3'd1;
  localparam logic [GOP_W-1:0] GOP_FOLD   = 3'd2;
  localparam logic [GOP_W-1:0] GOP_REDUCE = 3'd3;
  localparam logic [GOP_W-1:0] GOP_ACC    = 3'd4;
  localparam logic [GOP_W-1:0] GOP_PRIME  = 3'd5;

  typedef struct packed {
    logic [GOP_W-1:0]      op;
    logic [HASH_IDX_W-1:0] idx;
  } hash_ctrl_t;

  typedef struct packed {
    logic             start;
    logic [MERS_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } mod_rsp_t;

  // The j-th prime, j counted from 0.
  function automatic logic [7:0] prime_of(input logic [4:0] j);
    logic [7:0] p;
    case (j)
      5'd0:  p = 8'd2;
      5'd1:  p = 8'd3;
      5'd2:  p = 8'd5;
      5'd3:  p = 8'd7;
      5'd4:  p = 8'd11;
      5'd5:  p = 8'd13;
      5'd6:  p = 8'd17;
      5'd7:  p = 8'd19;
      5'd8:  p = 8'd23;
      5'd9:  p = 8'd29;
      5'd10: p = 8'd31;
      5'd11: p = 8'd37;
      5'd12: p = 8'd41;
      5'd13: p = 8'd43;
      5'd14: p = 8'd47;
      5'd15: p = 8'd53;
      5'd16: p = 8'd59;
      5'd17: p = 8'd61;
      5'd18: p = 8'd67;
      5'd19: p = 8'd71;
      5'd20: p = 8'd73;
      5'd21: p = 8'd79;
      5'd22: p = 8'd83;
      5'd23: p = 8'd89;
      5'd24: p = 8'd97;
      5'd25: p = 8'd101;
      5'd26: p = 8'd103;
      5'd27: p = 8'd107;
      5'd28: p = 8'd109;
      5'd29: p = 8'd113;
      5'd30: p = 8'd127;
      5'd31: p = 8'd131;
      default: p = 8'd2;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/bfiq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfiq_if: valid/ready channels of the Bloom filter core
// Request channel (request type and key) and result channel (found flag).
// ----------------------------------------------------------------------------
interface bfiq_in_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [bfiq_pkg::KEY_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface bfiq_out_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, output found, input ready);
  modport sink   (input valid, input found, output ready);
endinterface

// ----- rtl/bloom_filter_insert_query_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_core: Bloom filter add and search engine
// Sequencer, filter bit array and configuration registers around the shared
// hash generator and remainder unit.
// ----------------------------------------------------------------------------
// One request beat either adds a 64-bit key to the filter or searches for it;
// only a search returns a result beat (found). The core handles one request
// at a time and holds in_ch.ready low while it works. Each of the hash_count
// hashes runs the accumulate and prime steps of the hash generator, a
// division by the shared remainder unit (four quotient bits at a time, with
// issue and done) and a read-modify-write of the bit array; the first hash
// also folds and reduces the key, and a search then posts its result. A
// search stops at the first clear bit and is then shorter. With a hash_count
// of 0 an add is finished at its beat and a search goes straight to posting
// its result. A search result that finds the result register still full
// waits in place until the sink takes the older beat. After reset the bit
// array is cleared one 32-bit row per cycle, all 2048 rows, during which no
// request is taken; configuration writes are taken at any time and should be
// made only while the core is idle. A bit_count of 0 acts as 1 and one above
// 65536 acts as 65536; a hash_count above 16 acts as 16, and a hash_count of
// 0 makes an add do nothing and a search answer found = 1.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query_core (
  input  logic                                clk,
  input  logic                                rst_n,
  bfiq_in_if.sink                             in_ch,
  bfiq_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [bfiq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Sequencer states.
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_FOLD    = 4'd2;
  localparam logic [3:0] S_REDUCE  = 4'd3;
  localparam logic [3:0] S_ACC     = 4'd4;
  localparam logic [3:0] S_PRIME   = 4'd5;
  localparam logic [3:0] S_MODGO   = 4'd6;
  localparam logic [3:0] S_MODWAIT = 4'd7;
  localparam logic [3:0] S_CHK     = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  // Configuration registers.
  logic [bfiq_pkg::BIT_COUNT_W-1:0]  bit_count_r;
  logic [bfiq_pkg::HASH_COUNT_W-1:0] hash_count_r;

  // Sequencer and request state.
  logic [3:0]                       state_r, state_nxt;
  logic [bfiq_pkg::ROW_AW-1:0]      clr_r, clr_nxt;
  logic [bfiq_pkg::HASH_CNT_W-1:0]  j_r, j_nxt;
  logic                             search_r, search_nxt;
  logic                             found_r, found_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_found_r, out_found_nxt;

  // Effective sizes after clamping.
  logic [bfiq_pkg::DIV_W-1:0]       m_eff;
  logic [bfiq_pkg::HASH_CNT_W-1:0]  k_eff;
  logic                             last_hash;

  // Shared units.
  bfiq_pkg::hash_ctrl_t             hctrl;
  logic [bfiq_pkg::MERS_W-1:0]      hash_val;
  bfiq_pkg::mod_req_t               mreq;
  bfiq_pkg::mod_rsp_t               mrsp;

  // Bit array.
  logic [bfiq_pkg::ROW_W-1:0]       mem [bfiq_pkg::ROWS];
  logic [bfiq_pkg::ROW_W-1:0]       rd_data_r;
  logic [bfiq_pkg::ROW_AW-1:0]      rd_addr;
  logic                             mem_we;
  logic [bfiq_pkg::ROW_AW-1:0]      mem_waddr;
  logic [bfiq_pkg::ROW_W-1:0]       mem_wdata;
  logic [bfiq_pkg::ROW_AW-1:0]      idx_row;
  logic [bfiq_pkg::ROW_SEL_W-1:0]   idx_sel;
  logic                             idx_bit;
  logic                             in_accept;

  // The configuration registers are plain writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r  <= bfiq_pkg::BIT_COUNT_RST;
      hash_count_r <= bfiq_pkg::HASH_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == bfiq_pkg::REG_BIT_COUNT) begin
        bit_count_r <= cfg_data[bfiq_pkg::BIT_COUNT_W-1:0];
      end else if (cfg_index == bfiq_pkg::REG_HASH_COUNT) begin
        hash_count_r <= cfg_data[bfiq_pkg::HASH_COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (bit_count_r == '0) begin
      m_eff = bfiq_pkg::DIV_W'(1);
    end else if (32'(bit_count_r) > 32'(bfiq_pkg::MAX_BITS)) begin
      m_eff = bfiq_pkg::DIV_W'(bfiq_pkg::MAX_BITS);
    end else begin
      m_eff = bfiq_pkg::DIV_W'(bit_count_r);
    end
    if (32'(hash_count_r) > 32'(bfiq_pkg::MAX_HASHES)) begin
      k_eff = bfiq_pkg::HASH_CNT_W'(bfiq_pkg::MAX_HASHES);
    end else begin
      k_eff = bfiq_pkg::HASH_CNT_W'(hash_count_r);
    end
  end

  assign in_accept = in_ch.valid && in_ch.ready;
  assign last_hash = (j_r + 1'b1) == k_eff;

  // The remainder is the bit index: upper bits pick the row, lower the bit.
  assign idx_row = bfiq_pkg::ROW_AW'(mrsp.rem >> bfiq_pkg::ROW_SEL_W);
  assign idx_sel = mrsp.rem[bfiq_pkg::ROW_SEL_W-1:0];
  assign idx_bit = rd_data_r[idx_sel];

  bfiq_hash_gen u_hash_gen (
    .clk      (clk),
    .ctrl     (hctrl),
    .key      (in_ch.key),
    .hash_val (hash_val)
  );

  bfiq_mod_unit u_mod_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    j_nxt          = j_r;
    search_nxt     = search_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    hctrl.op       = bfiq_pkg::GOP_NONE;
    hctrl.idx      = bfiq_pkg::HASH_IDX_W'(j_r);
    mreq.start     = 1'b0;
    mreq.dividend  = hash_val;
    mreq.divisor   = m_eff;
    mem_we         = 1'b0;
    mem_waddr      = idx_row;
    mem_wdata      = rd_data_r | (bfiq_pkg::ROW_W'(1) << idx_sel);
    rd_addr        = idx_row;

    // The result register empties as soon as the sink takes its beat.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == bfiq_pkg::ROW_AW'(bfiq_pkg::ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          hctrl.op   = bfiq_pkg::GOP_LOAD;
          search_nxt = in_ch.req_type;
          found_nxt  = 1'b1;
          j_nxt      = '0;
          if (k_eff != '0) begin
            state_nxt = S_FOLD;
          end else if (in_ch.req_type) begin
            // No hashes: a search trivially matches.
            state_nxt = S_DONE;
          end
        end
      end
      S_FOLD: begin
        hctrl.op  = bfiq_pkg::GOP_FOLD;
        state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        hctrl.op  = bfiq_pkg::GOP_REDUCE;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        hctrl.op  = bfiq_pkg::GOP_ACC;
        state_nxt = S_PRIME;
      end
      S_PRIME: begin
        hctrl.op  = bfiq_pkg::GOP_PRIME;
        state_nxt = S_MODGO;
      end
      S_MODGO: begin
        mreq.start = 1'b1;
        state_nxt  = S_MODWAIT;
      end
      S_MODWAIT: begin
        // The row read goes out in the cycle the remainder is ready.
        if (mrsp.done) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (!search_r) begin
          mem_we = 1'b1;
          if (last_hash) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_ACC;
          end
        end else if (!idx_bit) begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end else if (last_hash) begin
          state_nxt = S_DONE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_ACC;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      j_r         <= '0;
      search_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      j_r         <= j_nxt;
      search_r    <= search_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
  end

  // Row memory with separate write and read addresses and registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.found = out_found_r;

endmodule

// ----- rtl/bfiq_hash_gen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfiq_hash_gen: hash value generator
// Reduces the key modulo 2^31-1 and steps through ((j+1)*r + prime_j) mod
// 2^31-1 by repeated addition, one add and conditional subtract per cycle.
// ----------------------------------------------------------------------------
module bfiq_hash_gen (
  input  logic                                clk,
  input  bfiq_pkg::hash_ctrl_t                ctrl,
  input  logic [bfiq_pkg::KEY_W-1:0]          key,
  output logic [bfiq_pkg::MERS_W-1:0]         hash_val
);

  localparam logic [31:0] M32 = 32'(bfiq_pkg::MERSENNE31);

  logic [32:0]                 t_r, t_nxt;
  logic [bfiq_pkg::MERS_W-1:0] r_r, r_nxt;
  logic [bfiq_pkg::MERS_W-1:0] acc_r, acc_nxt;
  logic [bfiq_pkg::MERS_W-1:0] v_r, v_nxt;
  logic [32:0]                 fold_a;
  logic [31:0]                 fold_b;
  logic [31:0]                 acc_sum;
  logic [31:0]                 prime_sum;

  always_comb begin
    // Fold the 64-bit key into 31-bit chunks; 2^31 == 1 modulo 2^31-1.
    fold_a    = 33'(key[30:0]) + 33'(key[61:31]) + 33'(key[63:62]);
    fold_b    = 32'(t_r[30:0]) + 32'(t_r[32:31]);
    acc_sum   = 32'(acc_r) + 32'(r_r);
    prime_sum = 32'(acc_r) + 32'(bfiq_pkg::prime_of(5'(ctrl.idx)));
    t_nxt     = t_r;
    r_nxt     = r_r;
    acc_nxt   = acc_r;
    v_nxt     = v_r;
    case (ctrl.op)
      bfiq_pkg::GOP_LOAD: begin
        t_nxt = fold_a;
      end
      bfiq_pkg::GOP_FOLD: begin
        t_nxt = 33'(fold_b);
      end
      bfiq_pkg::GOP_REDUCE: begin
        r_nxt   = (t_r[31:0] >= M32) ? 31'(t_r[31:0] - M32) : t_r[30:0];
        acc_nxt = '0;
      end
      bfiq_pkg::GOP_ACC: begin
        acc_nxt = (acc_sum >= M32) ? 31'(acc_sum - M32) : acc_sum[30:0];
      end
      bfiq_pkg::GOP_PRIME: begin
        v_nxt = (prime_sum >= M32) ? 31'(prime_sum - M32) : prime_sum[30:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    t_r   <= t_nxt;
    r_r   <= r_nxt;
    acc_r <= acc_nxt;
    v_r   <= v_nxt;
  end

  assign hash_val = v_r;

endmodule

// ----- rtl/bfiq_mod_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfiq_mod_unit: iterative remainder unit
// Restoring division that retires MOD_STEP dividend bits per cycle and
// returns the remainder with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module bfiq_mod_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  bfiq_pkg::mod_req_t  req,
  output bfiq_pkg::mod_rsp_t  rsp
);

  logic [bfiq_pkg::DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [bfiq_pkg::DIV_W-1:0]     div_r, div_nxt;
  logic [bfiq_pkg::DIV_W-1:0]     rem_r, rem_nxt;
  logic [bfiq_pkg::MOD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [bfiq_pkg::DIV_W-1:0]     rem_w;
  logic [bfiq_pkg::DIV_W:0]       sh;

  always_comb begin
    rem_w    = rem_r;
    sh       = '0;
    for (int i = 0; i < bfiq_pkg::MOD_STEP; i++) begin
      sh    = {rem_w, dvd_r[bfiq_pkg::DVD_W-1-i]};
      rem_w = (sh >= {1'b0, div_r}) ? bfiq_pkg::DIV_W'(sh - {1'b0, div_r})
                                    : bfiq_pkg::DIV_W'(sh);
    end
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = bfiq_pkg::DVD_W'(req.dividend);
      div_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << bfiq_pkg::MOD_STEP;
      rem_nxt = rem_w;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == bfiq_pkg::MOD_CNT_W'(bfiq_pkg::MOD_CYC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = bfiq_pkg::IDX_W'(rem_r);

endmodule
